/* hw/rtl/mfep_pkg.sv */
// shared types and constants for the midi file event parser
`default_nettype none
package mfep_pkg;

  localparam int TICK_BITS = 40;
  localparam int MAX_VLQ_BYTES = 4;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_EVENT  = 3'd1;
  localparam logic [2:0] KIND_TEMPO  = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  localparam logic [2:0] ERR_NOT_SMF  = 3'd0;
  localparam logic [2:0] ERR_HEADER   = 3'd1;
  localparam logic [2:0] ERR_TRUNC    = 3'd2;
  localparam logic [2:0] ERR_DELTA    = 3'd3;
  localparam logic [2:0] ERR_NOSTATUS = 3'd4;
  localparam logic [2:0] ERR_META     = 3'd5;
  localparam logic [2:0] ERR_SYSEX    = 3'd6;
  localparam logic [2:0] ERR_CHANNEL  = 3'd7;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] track_index;
    logic [39:0] tick;
    logic [7:0]  status;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [23:0] tempo_us;
    logic [2:0]  error_code;
    logic [15:0] track_count;
    logic [15:0] time_division;
    logic        run_end;
  } out_item_t;

  // one byte's worth of results: up to two
  typedef struct packed {
    logic      [1:0] count;
    out_item_t       r0;
    out_item_t       r1;
  } res_pair_t;

endpackage
`default_nettype wire

/* hw/rtl/mfep_front.sv */
// front part: per-byte parse state machine producing result pairs
`default_nettype none
module mfep_front import mfep_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  in_item_t  in_data,
  input  wire       step,
  output res_pair_t res
);

  localparam logic [4:0] PH_HEAD = 5'd0, PH_HSKIP = 5'd1, PH_CHDR = 5'd2, PH_TAIL = 5'd3,
    PH_ERR = 5'd4, PH_CSKIP = 5'd5, PH_DELTA = 5'd6, PH_STATUS = 5'd7, PH_DATA1 = 5'd8,
    PH_DATA2 = 5'd9, PH_MTYPE = 5'd10, PH_MLEN = 5'd11, PH_TEMPO = 5'd12,
    PH_MSKIP = 5'd13, PH_SLEN = 5'd14;

  localparam logic [TICK_BITS-1:0] TICK_LIM = {TICK_BITS{1'b1}};

  logic [4:0]  phase, phase_next;
  logic [3:0]  fbc, fbc_next, bss, bss_next;
  logic [31:0] hrem, hrem_next, crem, crem_next, vlq, vlq_next, skip, skip_next;
  logic        is_trk, is_trk_next;
  logic [15:0] dtr, dtr_next, ctr, ctr_next, div, div_next;
  logic [TICK_BITS-1:0] tick, tick_next;
  logic [7:0]  rs, rs_next, est, est_next, mtype, mtype_next, fd, fd_next;
  logic [23:0] tempo, tempo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD; fbc <= '0; bss <= '0; hrem <= '0; crem <= '0; is_trk <= 1'b0;
      dtr <= '0; ctr <= '0; tick <= '0; rs <= '0; vlq <= '0; est <= '0; mtype <= '0;
      skip <= '0; tempo <= '0; fd <= '0; div <= '0;
    end else if (step) begin
      phase <= phase_next; fbc <= fbc_next; bss <= bss_next; hrem <= hrem_next;
      crem <= crem_next; is_trk <= is_trk_next; dtr <= dtr_next; ctr <= ctr_next;
      tick <= tick_next; rs <= rs_next; vlq <= vlq_next; est <= est_next;
      mtype <= mtype_next; skip <= skip_next; tempo <= tempo_next; fd <= fd_next;
      div <= div_next;
    end
  end

  function automatic logic [7:0] head_magic(input logic [1:0] i);
    case (i)
      2'd0: head_magic = 8'h4D;
      2'd1: head_magic = 8'h54;
      2'd2: head_magic = 8'h68;
      default: head_magic = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] trk_magic(input logic [1:0] i);
    case (i)
      2'd0: trk_magic = 8'h4D;
      2'd1: trk_magic = 8'h54;
      2'd2: trk_magic = 8'h72;
      default: trk_magic = 8'h6B;
    endcase
  endfunction

  // tick of an event: delta never emits an event or tempo, so the registered tick holds
  function automatic logic [TICK_BITS-1:0] tick_next_pre(input logic [TICK_BITS-1:0] t,
      input logic [4:0] p, input logic [TICK_BITS-1:0] tn, input logic l);
    tick_next_pre = (p == PH_CHDR && !l) ? tn : t;
  endfunction

  function automatic logic [15:0] dtr_hold(input logic [15:0] dd, input logic [7:0] bb,
      input logic [3:0] i);
    dtr_hold = (i == 4'd13) ? dd : {dd[7:0], bb};
  endfunction

  function automatic logic [31:0] crem_next_pre(input logic [31:0] c, input logic [4:0] p);
    crem_next_pre = (p >= PH_CSKIP) ? c - 32'd1 : c;
  endfunction

  // the error after the byte sees the track index after any chunk end
  function automatic logic [15:0] ctr_after(input logic [15:0] c, input logic e,
      input logic [31:0] cr);
    ctr_after = (e && cr == 32'd0) ? c + 16'd1 : c;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic last, at_end, vdone, verr, consumed, bail;
    logic [7:0] st;
    logic [3:0] fi;
    logic [2:0] ci;
    logic [TICK_BITS-1:0] d;
    logic [1:0] n;
    logic [2:0] k0, k1, e0, e1;
    logic [7:0] s0;
    logic [6:0] a0, b0;
    logic [23:0] t0;
    logic [15:0] trk0, trk1, tc0, dv0;
    logic [TICK_BITS-1:0] tk0;
    logic ee;

    b = in_data.file_byte;
    last = in_data.final_byte;
    phase_next = phase; fbc_next = fbc; bss_next = bss; hrem_next = hrem;
    crem_next = crem; is_trk_next = is_trk; dtr_next = dtr; ctr_next = ctr;
    tick_next = tick; rs_next = rs; vlq_next = vlq; est_next = est;
    mtype_next = mtype; skip_next = skip; tempo_next = tempo; fd_next = fd;
    div_next = div;
    n = 2'd0; k0 = KIND_DONE; k1 = KIND_DONE; e0 = '0; e1 = '0;
    s0 = '0; a0 = '0; b0 = '0; t0 = '0; ee = 1'b0;
    at_end = 1'b0; vdone = 1'b0; verr = 1'b0; consumed = 1'b0; st = '0; fi = '0;
    ci = '0; d = '0; bail = 1'b0;
    // event_end, captured as a flag and applied below
    if (last && phase >= PH_CSKIP && crem > 32'd1) begin
      n = 2'd1; k0 = KIND_ERROR; e0 = ERR_TRUNC; phase_next = PH_ERR;
    end else if (phase != PH_ERR) begin
      if (phase == PH_HEAD) begin
        fi = bss;
        if (fi < 4'd4) begin
          if (b != head_magic(fi[1:0])) begin
            n = 2'd1; k0 = KIND_ERROR; e0 = ERR_NOT_SMF; phase_next = PH_ERR; bail = 1'b1;
          end
        end else if (fi < 4'd8) hrem_next = {hrem[23:0], b};
        else if (fi == 4'd10 || fi == 4'd11) dtr_next = {dtr[7:0], b};
        else if (fi == 4'd12 || fi == 4'd13) div_next = {div[7:0], b};
        if (!bail) begin
          bss_next = fi + 4'd1;
          if (fi == 4'd13) begin
            if (hrem < 32'd6) begin
              n = 2'd1; k0 = KIND_ERROR; e0 = ERR_HEADER; phase_next = PH_ERR;
            end else begin
              hrem_next = hrem - 32'd6;
              n = 2'd1; k0 = KIND_HEADER;
              if (hrem != 32'd6) phase_next = PH_HSKIP;
              else begin
                fbc_next = '0;
                phase_next = (ctr >= dtr_next) ? PH_TAIL : PH_CHDR;
              end
            end
          end
        end
      end else if (phase == PH_HSKIP) begin
        hrem_next = hrem - 32'd1;
        if (hrem == 32'd1) begin
          fbc_next = '0; phase_next = (ctr >= dtr) ? PH_TAIL : PH_CHDR;
        end
      end else if (phase == PH_CHDR) begin
        ci = fbc[2:0];
        is_trk_next = (ci == 3'd0) ? 1'b1 : is_trk;
        if (ci[2] == 1'b0) begin
          if (ci == 3'd0) crem_next = '0;
          if (b != trk_magic(ci[1:0])) is_trk_next = 1'b0;
        end else crem_next = {crem[23:0], b};
        fbc_next = {1'b0, ci} + 4'd1;
        if (ci == 3'd7) begin
          if (is_trk_next) begin tick_next = '0; rs_next = '0; end
          if (crem_next == 32'd0) ee = 1'b1;
          else if (is_trk_next) begin vlq_next = '0; fbc_next = '0; phase_next = PH_DELTA; end
          else phase_next = PH_CSKIP;
        end
      end else if (phase >= PH_CSKIP) begin
        crem_next = crem - 32'd1;
        at_end = (crem == 32'd1);
        vlq_next = {vlq[24:0], b[6:0]};
        if (fbc != 4'd15) fi = fbc + 4'd1; else fi = fbc;
        if (b[7]) begin
          verr = (fi >= 4'(MAX_VLQ_BYTES)) || at_end;
        end else vdone = 1'b1;
        case (phase)
          PH_CSKIP: begin vlq_next = vlq; if (at_end) ee = 1'b1; end
          PH_DELTA: begin
            fbc_next = fi;
            if (verr || (vdone && at_end)) begin
              n = 2'd1; k0 = KIND_ERROR; e0 = ERR_DELTA; phase_next = PH_ERR;
            end else if (vdone) begin
              d = TICK_BITS'(vlq_next);
              tick_next = (tick > TICK_LIM - d) ? TICK_LIM : tick + d;
              phase_next = PH_STATUS;
            end
          end
          PH_STATUS: begin
            vlq_next = vlq;
            consumed = b[7];
            st = consumed ? b : rs;
            if (!st[7]) begin
              n = 2'd1; k0 = KIND_ERROR; e0 = ERR_NOSTATUS; phase_next = PH_ERR;
            end else if (st == 8'hFF) begin
              rs_next = '0;
              if (at_end) begin
                n = 2'd1; k0 = KIND_ERROR; e0 = ERR_META; phase_next = PH_ERR;
              end else phase_next = PH_MTYPE;
            end else if (st == 8'hF0 || st == 8'hF7) begin
              rs_next = '0;
              if (at_end) begin
                n = 2'd1; k0 = KIND_ERROR; e0 = ERR_SYSEX; phase_next = PH_ERR;
              end else begin vlq_next = '0; fbc_next = '0; phase_next = PH_SLEN; end
            end else begin
              rs_next = st; est_next = st;
              if (!consumed) begin
                fd_next = b;
                if (st[7:5] == 3'b110) begin
                  n = 2'd1; k0 = KIND_EVENT; s0 = st; a0 = b[6:0]; ee = 1'b1;
                end else if (at_end) begin
                  n = 2'd1; k0 = KIND_ERROR; e0 = ERR_CHANNEL; phase_next = PH_ERR;
                end else phase_next = PH_DATA2;
              end else if (at_end) begin
                n = 2'd1; k0 = KIND_ERROR; e0 = ERR_CHANNEL; phase_next = PH_ERR;
              end else phase_next = PH_DATA1;
            end
          end
          PH_DATA1: begin
            vlq_next = vlq; fd_next = b;
            if (est[7:5] == 3'b110) begin
              n = 2'd1; k0 = KIND_EVENT; s0 = est; a0 = b[6:0]; ee = 1'b1;
            end else if (at_end) begin
              n = 2'd1; k0 = KIND_ERROR; e0 = ERR_CHANNEL; phase_next = PH_ERR;
            end else phase_next = PH_DATA2;
          end
          PH_DATA2: begin
            vlq_next = vlq;
            n = 2'd1; k0 = KIND_EVENT; s0 = est; a0 = fd[6:0]; b0 = b[6:0]; ee = 1'b1;
          end
          PH_MTYPE: begin
            mtype_next = b;
            if (at_end) begin
              vlq_next = vlq; n = 2'd1; k0 = KIND_ERROR; e0 = ERR_META; phase_next = PH_ERR;
            end else begin vlq_next = '0; fbc_next = '0; phase_next = PH_MLEN; end
          end
          PH_MLEN, PH_SLEN: begin
            fbc_next = fi;
            if (verr) begin
              n = 2'd1; k0 = KIND_ERROR; phase_next = PH_ERR;
              e0 = (phase == PH_MLEN) ? ERR_META : ERR_SYSEX;
            end else if (vdone) begin
              if (vlq_next > crem_next) begin
                n = 2'd1; k0 = KIND_ERROR; phase_next = PH_ERR;
                e0 = (phase == PH_MLEN) ? ERR_META : ERR_SYSEX;
              end else if (vlq_next == 32'd0) ee = 1'b1;
              else begin
                skip_next = vlq_next;
                if (phase == PH_MLEN && mtype == 8'h51 && vlq_next == 32'd3) begin
                  tempo_next = '0; phase_next = PH_TEMPO;
                end else phase_next = PH_MSKIP;
              end
            end
          end
          PH_TEMPO: begin
            vlq_next = vlq;
            tempo_next = {tempo[15:0], b};
            skip_next = skip - 32'd1;
            if (skip == 32'd1) begin
              n = 2'd1; k0 = KIND_TEMPO; t0 = tempo_next; ee = 1'b1;
            end
          end
          default: begin
            vlq_next = vlq;
            skip_next = skip - 32'd1;
            if (skip == 32'd1) ee = 1'b1;
          end
        endcase
      end
      if (ee) begin
        if (crem_next == 32'd0) begin
          ctr_next = ctr + 16'd1; fbc_next = '0;
          phase_next = (ctr + 16'd1 >= dtr_next) ? PH_TAIL : PH_CHDR;
        end else begin vlq_next = '0; fbc_next = '0; phase_next = PH_DELTA; end
      end
      if (last && phase_next != PH_ERR) begin
        if (phase_next == PH_HEAD) begin k1 = KIND_ERROR; e1 = ERR_NOT_SMF; end
        else if (phase_next == PH_HSKIP) begin k1 = KIND_ERROR; e1 = ERR_HEADER; end
        else if (phase_next >= PH_CSKIP) begin k1 = KIND_ERROR; e1 = ERR_TRUNC; end
        else k1 = KIND_DONE;
        if (n == 2'd0) begin k0 = k1; e0 = e1; n = 2'd1; end else n = 2'd2;
      end
    end
    if (last) begin
      phase_next = PH_HEAD; fbc_next = '0; bss_next = '0; hrem_next = '0; crem_next = '0;
      is_trk_next = 1'b0; dtr_next = '0; ctr_next = '0; tick_next = '0; rs_next = '0;
      vlq_next = '0; est_next = '0; mtype_next = '0; skip_next = '0; tempo_next = '0;
      fd_next = '0; div_next = '0;
    end

    // field values use state as it stands when the result is emitted
    trk0 = (k0 == KIND_EVENT || k0 == KIND_TEMPO || k0 == KIND_ERROR) ? ctr : 16'd0;
    tk0 = (k0 == KIND_EVENT || k0 == KIND_TEMPO) ? tick_next_pre(tick, phase, tick_next,
          last) : '0;
    tc0 = (k0 == KIND_HEADER) ? dtr_hold(dtr, b, bss) : 16'd0;
    dv0 = (k0 == KIND_HEADER) ? {div[7:0], b} : 16'd0;
    trk1 = (k1 == KIND_ERROR) ? ctr_after(ctr, ee, crem_next_pre(crem, phase)) : 16'd0;

    res.count = n;
    res.r0 = '{kind: k0, track_index: trk0, tick: tk0[39:0], status: s0, data1: a0,
               data2: b0, tempo_us: t0, error_code: e0, track_count: tc0,
               time_division: dv0, run_end: (n == 2'd1)};
    res.r1 = '{kind: k1, track_index: trk1, tick: '0, status: '0, data1: '0, data2: '0,
               tempo_us: '0, error_code: e1, track_count: '0, time_division: '0,
               run_end: 1'b1};
  end

endmodule
`default_nettype wire

/* hw/rtl/mfep_queue.sv */
// short queue of result pairs between front and back
`default_nettype none
module mfep_queue import mfep_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       push,
  input  res_pair_t push_data,
  output logic      full,
  input  wire       pop,
  output res_pair_t head,
  output logic      empty
);

  res_pair_t   slots [2];
  logic        wp, rp;
  logic [1:0]  cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mfep_back.sv */
// back part: issues the one or two results of each queued pair
`default_nettype none
module mfep_back import mfep_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  res_pair_t head,
  input  wire       empty,
  output logic      pop,
  output logic      valid,
  input  wire       stall,
  output out_item_t result
);

  logic second;

  assign valid  = !empty;
  assign result = second ? head.r1 : head.r0;
  // a pair is retired once its last result moves
  assign pop = !empty && !stall && (second || head.count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) second <= 1'b0;
    else if (!empty && !stall) second <= !second && head.count == 2'd2;
  end

endmodule
`default_nettype wire

/* hw/rtl/midi_file_event_parser.sv */
// top level of the midi file event parser
// Parses a Standard MIDI File one byte per transaction and reports header, channel event,
// tempo, error and done results. The parse state machine updates its state on each accepted
// byte; its zero, one or two results go through a two-entry queue and leave one per cycle
// while out_stall is low. Input stalls only when the queue fills.
`default_nettype none
module midi_file_event_parser import mfep_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire       out_stall,
  output out_item_t out_data
);

  res_pair_t res, head;
  logic full, empty, pop, step;

  assign in_stall = full;
  assign step = in_valid && !full;

  mfep_front u_front (.clk(clk), .rst(rst), .in_data(in_data), .step(step), .res(res));

  mfep_queue u_queue (.clk(clk), .rst(rst), .push(step && res.count != 2'd0),
    .push_data(res), .full(full), .pop(pop), .head(head), .empty(empty));

  mfep_back u_back (.clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop),
    .valid(out_valid), .stall(out_stall), .result(out_data));

endmodule
`default_nettype wire

/* bench/smf_result_checker.sv */
// checker for the midi file parser: follows the byte stream and compares every result
module smf_result_checker import mfep_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  input  wire       in_stall,
  input  in_item_t  in_data,
  input  wire       out_valid,
  input  wire       out_stall,
  input  out_item_t out_data,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    S_HEAD, S_HSKIP, S_CHDR, S_TAIL, S_ERR,
    S_CSKIP, S_DELTA, S_STATUS, S_DATA1, S_DATA2,
    S_MTYPE, S_MLEN, S_TEMPO, S_MSKIP, S_SLEN
  } parse_st_t;

  localparam logic [7:0] HDR_TAG [4] = '{8'h4D, 8'h54, 8'h68, 8'h64};
  localparam logic [7:0] TRK_TAG [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};
  localparam logic [7:0] ST_META  = 8'hFF;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_ESCAPE = 8'hF7;
  localparam logic [7:0] SET_TEMPO = 8'h51;

  parse_st_t   ph;
  logic [3:0]  fbc, bss;
  logic [31:0] hdr_rem, chk_rem, vlq, skip;
  logic        is_trk;
  logic [15:0] ntracks, cur_trk, div;
  logic [39:0] tick;
  logic [7:0]  run_st, ev_st, mtype, d1;
  logic [23:0] tempo;

  out_item_t step_res [2];
  int        n_res;
  out_item_t want_q [$];

  task automatic clear_parse();
    ph = S_HEAD; fbc = '0; bss = '0; hdr_rem = '0; chk_rem = '0; is_trk = 1'b0;
    ntracks = '0; cur_trk = '0; tick = '0; run_st = '0; vlq = '0; ev_st = '0;
    mtype = '0; skip = '0; tempo = '0; d1 = '0; div = '0;
  endtask

  task automatic add_res(input logic [2:0] k, input logic [7:0] st, input logic [7:0] a,
                         input logic [7:0] b, input logic [23:0] tp, input logic [2:0] code);
    out_item_t r;
    if (n_res >= 2) return;
    r = '0;
    r.kind = k;
    if (k == KIND_EVENT || k == KIND_TEMPO || k == KIND_ERROR) r.track_index = cur_trk;
    if (k == KIND_EVENT || k == KIND_TEMPO) r.tick = tick;
    r.status = st;
    r.data1 = a[6:0];
    r.data2 = b[6:0];
    r.tempo_us = tp;
    r.error_code = code;
    if (k == KIND_HEADER) begin
      r.track_count = ntracks;
      r.time_division = div;
    end
    step_res[n_res] = r;
    n_res++;
  endtask

  task automatic raise(input logic [2:0] code);
    add_res(KIND_ERROR, 8'd0, 8'd0, 8'd0, 24'd0, code);
    ph = S_ERR;
  endtask

  task automatic enter_chunk();
    fbc = '0;
    ph = (cur_trk >= ntracks) ? S_TAIL : S_CHDR;
  endtask

  task automatic start_vlq(input parse_st_t nxt);
    vlq = '0;
    fbc = '0;
    ph = nxt;
  endtask

  task automatic event_done();
    if (chk_rem == 0) begin
      cur_trk = cur_trk + 16'd1;
      enter_chunk();
    end else begin
      start_vlq(S_DELTA);
    end
  endtask

  // r: 1 value complete, 0 more bytes follow, -1 too long or cut by chunk end
  task automatic vlq_shift(input logic [7:0] b, input logic at_end, output int r);
    vlq = {vlq[24:0], b[6:0]};
    if (fbc < 4'd15) fbc = fbc + 4'd1;
    if (b[7]) r = (fbc >= MAX_VLQ_BYTES || at_end) ? -1 : 0;
    else r = 1;
  endtask

  task automatic data_first(input logic [7:0] b, input logic at_end);
    d1 = b;
    if (ev_st[7:5] == 3'b110) begin
      add_res(KIND_EVENT, ev_st, b, 8'd0, 24'd0, 3'd0);
      event_done();
    end else if (at_end) begin
      raise(ERR_CHANNEL);
    end else begin
      ph = S_DATA2;
    end
  endtask

  task automatic len_done(input logic [2:0] code, input logic is_meta);
    if (vlq > chk_rem) raise(code);
    else if (vlq == 0) event_done();
    else begin
      skip = vlq;
      if (is_meta && mtype == SET_TEMPO && vlq == 32'd3) begin
        tempo = '0;
        ph = S_TEMPO;
      end else begin
        ph = S_MSKIP;
      end
    end
  endtask

  task automatic body_byte(input logic [7:0] b);
    logic        at_end, used, meta;
    logic [7:0]  st;
    logic [40:0] sum;
    int          r;
    chk_rem = chk_rem - 32'd1;
    at_end = (chk_rem == 0);
    case (ph)
      S_CSKIP: if (at_end) event_done();
      S_DELTA: begin
        vlq_shift(b, at_end, r);
        if (r < 0 || (r > 0 && at_end)) raise(ERR_DELTA);
        else if (r > 0) begin
          sum = {1'b0, tick} + {9'd0, vlq};
          tick = sum[40] ? '1 : sum[39:0];
          ph = S_STATUS;
        end
      end
      S_STATUS: begin
        used = b[7];
        st = used ? b : run_st;
        if (!st[7]) raise(ERR_NOSTATUS);
        else if (st == ST_META) begin
          run_st = '0;
          if (at_end) raise(ERR_META); else ph = S_MTYPE;
        end else if (st == ST_SYSEX || st == ST_ESCAPE) begin
          run_st = '0;
          if (at_end) raise(ERR_SYSEX); else start_vlq(S_SLEN);
        end else begin
          run_st = st;
          ev_st = st;
          if (!used) data_first(b, at_end);
          else if (at_end) raise(ERR_CHANNEL);
          else ph = S_DATA1;
        end
      end
      S_DATA1: data_first(b, at_end);
      S_DATA2: begin
        add_res(KIND_EVENT, ev_st, d1, b, 24'd0, 3'd0);
        event_done();
      end
      S_MTYPE: begin
        mtype = b;
        if (at_end) raise(ERR_META); else start_vlq(S_MLEN);
      end
      S_MLEN, S_SLEN: begin
        meta = (ph == S_MLEN);
        vlq_shift(b, at_end, r);
        if (r < 0) raise(meta ? ERR_META : ERR_SYSEX);
        else if (r > 0) len_done(meta ? ERR_META : ERR_SYSEX, meta);
      end
      S_TEMPO: begin
        tempo = {tempo[15:0], b};
        skip = skip - 32'd1;
        if (skip == 0) begin
          add_res(KIND_TEMPO, 8'd0, 8'd0, 8'd0, tempo, 3'd0);
          event_done();
        end
      end
      default: begin
        skip = skip - 32'd1;
        if (skip == 0) event_done();
      end
    endcase
  endtask

  task automatic head_byte(input logic [7:0] b);
    logic [3:0] i;
    i = bss;
    if (i < 4) begin
      if (b != HDR_TAG[i[1:0]]) begin
        raise(ERR_NOT_SMF);
        return;
      end
    end else if (i < 8) hdr_rem = {hdr_rem[23:0], b};
    else if (i == 10 || i == 11) ntracks = {ntracks[7:0], b};
    else if (i == 12 || i == 13) div = {div[7:0], b};
    bss = i + 4'd1;
    if (i == 13) begin
      if (hdr_rem < 6) begin
        raise(ERR_HEADER);
        return;
      end
      hdr_rem = hdr_rem - 32'd6;
      add_res(KIND_HEADER, 8'd0, 8'd0, 8'd0, 24'd0, 3'd0);
      if (hdr_rem > 0) ph = S_HSKIP;
      else enter_chunk();
    end
  endtask

  task automatic chunk_head_byte(input logic [7:0] b);
    logic [2:0] i;
    i = fbc[2:0];
    if (i == 0) begin
      is_trk = 1'b1;
      chk_rem = '0;
    end
    if (i < 4) begin
      if (b != TRK_TAG[i[1:0]]) is_trk = 1'b0;
    end else begin
      chk_rem = {chk_rem[23:0], b};
    end
    fbc = {1'b0, i} + 4'd1;
    if (i == 7) begin
      if (is_trk) begin
        tick = '0;
        run_st = '0;
      end
      if (chk_rem == 0) event_done();
      else if (is_trk) start_vlq(S_DELTA);
      else ph = S_CSKIP;
    end
  endtask

  task automatic parse_byte(input in_item_t it);
    n_res = 0;
    if (it.final_byte && ph >= S_CSKIP && chk_rem > 1) begin
      raise(ERR_TRUNC);
    end else if (ph != S_ERR) begin
      if (ph == S_HEAD) head_byte(it.file_byte);
      else if (ph == S_HSKIP) begin
        hdr_rem = hdr_rem - 32'd1;
        if (hdr_rem == 0) enter_chunk();
      end else if (ph == S_CHDR) chunk_head_byte(it.file_byte);
      else if (ph >= S_CSKIP) body_byte(it.file_byte);
      if (it.final_byte && ph != S_ERR) begin
        if (ph == S_HEAD) raise(ERR_NOT_SMF);
        else if (ph == S_HSKIP) raise(ERR_HEADER);
        else if (ph >= S_CSKIP) raise(ERR_TRUNC);
        else add_res(KIND_DONE, 8'd0, 8'd0, 8'd0, 24'd0, 3'd0);
      end
    end
    if (it.final_byte) clear_parse();
    if (n_res > 0) step_res[n_res - 1].run_end = 1'b1;
    for (int k = 0; k < n_res; k++) want_q = {want_q, step_res[k]};
  endtask

  task automatic note_fail(input string what, input out_item_t e, input out_item_t a);
    errors++;
    if (errors <= 10) $display("mismatch (%s): expected %p got %p", what, e, a);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      want_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_data);
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) note_fail("unexpected result", '0, out_data);
        else if (out_data !== want_q[0]) begin
          note_fail("field", want_q[0], out_data);
          void'(want_q.pop_front());
        end else void'(want_q.pop_front());
      end
    end
    pending <= want_q.size();
  end

endmodule

/* bench/midi_file_event_parser_tb.sv */
// testbench top: builds midi files byte by byte, drives the parser and gives the verdict
module midi_file_event_parser_tb;
  import mfep_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        errors, pending;

  int        send_idle, recv_idle, sent;
  int        cycles = 0;
  logic [7:0] fb [$];
  logic [7:0] tb_body [$];

  midi_file_event_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  smf_result_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, last};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_file();
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic put_byte(input logic [7:0] v);
    fb = {fb, v};
  endtask

  task automatic put_body(input logic [7:0] v);
    tb_body = {tb_body, v};
  endtask

  task automatic push32(input logic [31:0] v);
    put_byte(v[31:24]); put_byte(v[23:16]);
    put_byte(v[15:8]);  put_byte(v[7:0]);
  endtask

  task automatic push16(input logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic push_vlq(input logic [31:0] v);
    logic [7:0] g [$];
    g.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      g.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (g[i]) put_body(g[i]);
  endtask

  task automatic build_track();
    int         pick, n, len;
    logic       have;
    logic [7:0] st;
    tb_body.delete();
    have = 1'b0;
    st = 8'h90;
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(99);
      if (pick < 3) repeat (5) put_body(8'h81);
      else if (pick < 75) push_vlq($urandom_range(0, 127));
      else if (pick < 95) push_vlq($urandom_range(128, 32'h0FFF_FFFF));
      else push_vlq(32'h0FFF_FFFF);
      pick = $urandom_range(99);
      if (pick < 55) begin
        // running status reuses the last channel status
        if (!(have && $urandom_range(2) == 0)) begin
          st = 8'($urandom_range(8'h80, 8'hEF));
          if ($urandom_range(19) == 0) st = 8'($urandom_range(8'hF1, 8'hFE));
          if (st == 8'hF7) st = 8'hF1;
          put_body(st);
          have = 1'b1;
        end
        n = (st[7:5] == 3'b110) ? 1 : 2;
        repeat (n) put_body(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(127)));
      end else if (pick < 65) begin
        put_body(8'hFF); put_body(8'h51); put_body(8'h03);
        repeat (3) put_body(8'($urandom_range(255)));
        have = 1'b0;
      end else if (pick < 80) begin
        put_body(8'hFF);
        put_body(8'($urandom_range(255)));
        len = $urandom_range(0, 4);
        push_vlq(len);
        repeat (len) put_body(8'($urandom_range(255)));
        have = 1'b0;
      end else if (pick < 94) begin
        put_body(($urandom_range(1) != 0) ? 8'hF0 : 8'hF7);
        len = $urandom_range(0, 4);
        push_vlq(len);
        repeat (len) put_body(8'($urandom_range(255)));
        have = 1'b0;
      end else begin
        // data byte where a status is due
        put_body(8'($urandom_range(127)));
      end
    end
  endtask

  task automatic build_file();
    int          r, ntr, len;
    logic [31:0] hl;
    fb.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(255)));
      return;
    end
    put_byte(8'h4D); put_byte(8'h54); put_byte(8'h68); put_byte(8'h64);
    if ($urandom_range(19) == 0) fb[$urandom_range(3)] = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 85) hl = 32'd6;
    else if (r < 92) hl = $urandom_range(0, 5);
    else if (r < 98) hl = $urandom_range(7, 10);
    else hl = 32'hFFFF_FFF0;
    push32(hl);
    push16(16'($urandom_range(2)));
    ntr = $urandom_range(0, 3);
    push16(16'(ntr));
    push16(16'($urandom_range(16'hFFFF)));
    if (hl > 6 && hl <= 10) repeat (hl - 6) put_byte(8'($urandom_range(255)));
    repeat (ntr + ($urandom_range(9) == 0)) begin
      if ($urandom_range(6) == 0) begin
        put_byte(8'h4D); put_byte(8'h54);
        put_byte(8'($urandom_range(255))); put_byte(8'($urandom_range(255)));
        len = $urandom_range(0, 6);
        push32(len);
        repeat (len) put_byte(8'($urandom_range(255)));
      end else begin
        build_track();
        len = tb_body.size();
        r = $urandom_range(99);
        if (r < 10) len = len + $urandom_range(1, 3);
        else if (r < 15) len = $urandom_range(0, len);
        put_byte(8'h4D); put_byte(8'h54); put_byte(8'h72); put_byte(8'h6B);
        push32(len);
        foreach (tb_body[i]) put_byte(tb_body[i]);
      end
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
    if ($urandom_range(6) == 0 && fb.size() > 1) begin
      r = $urandom_range(1, fb.size());
      fb = fb[0:r-1];
    end
  endtask

  initial begin
    sent = 0;
    send_idle = 16;
    recv_idle = 45;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // bad magic, file cut inside the header, then a header with no tracks and a tail byte
    fb = '{8'h4D, 8'h00};
    send_file();
    fb = '{8'h4D, 8'h54};
    send_file();
    fb = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
           8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE0, 8'hFF};
    send_file();

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 16 : (p == 1) ? 45 : 0;
      recv_idle = (p == 0) ? 45 : (p == 1) ? 16 : 0;
      while (sent < (p + 1) * 200) begin
        build_file();
        send_file();
      end
      in_valid <= 1'b0;
      if (p == 0) begin
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mfep_pkg.sv
hw/rtl/mfep_front.sv
hw/rtl/mfep_queue.sv
hw/rtl/mfep_back.sv
hw/rtl/midi_file_event_parser.sv
bench/smf_result_checker.sv
bench/midi_file_event_parser_tb.sv
